@@ rtl/shrp_pkg.sv @@
// shrp_pkg: shared types and constants of the 3x3 sharpening stream filter
// no dependencies; used by sharpen_3x3_stream
package shrp_pkg;

    // register indexes on the configuration port
    localparam logic [1:0] REG_WIDTH    = 2'd0;
    localparam logic [1:0] REG_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_CHANNELS = 2'd2;

    // register reset values
    localparam logic [11:0] WIDTH_RESET    = 12'd640;
    localparam logic [12:0] HEIGHT_RESET   = 13'd480;
    localparam logic [2:0]  CHANNELS_RESET = 3'd3;

    // samples one row may span, and the frame height limit
    localparam int STORE_LIMIT = 8192;
    localparam int HEIGHT_CAP  = 4096;

    // effective geometry, worked out when a register is written
    typedef struct packed {
        logic [2:0]  chans;
        logic [13:0] len;
        logic [13:0] inner_end;
        logic [12:0] height;
        logic [12:0] last_row;
    } cfg_t;

    // one output sample with its coordinates
    typedef struct packed {
        logic [7:0]  value;
        logic [11:0] row;
        logic [12:0] index;
        logic        last;
    } result_t;

endpackage

@@ rtl/sharpen_3x3_stream.sv @@
// sharpen_3x3_stream: streaming 3x3 sharpening filter with two row stores
// depends on shrp_pkg (types, register indexes, limits)
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+----------------------------------
//  sample   | in        | sample_valid / sample_ready  | sample
//  result   | out       | result_valid / result_ready  | pixel_value, out_row, out_index,
//           |           |                              | frame_last
//  config   | in        | psel / penable / pready      | paddr, pwrite, pwdata, prdata
//
// one sample request is taken per clock unless the pipeline stalls; a result passes
// the stage-one register and then the output register; the final row gives two results
// per sample and so is slower, set by the single output register draining one per clock
// the row stores are read at accept and the upper row is written back one stage later
// reset clears counters and pipeline valid bits and loads the configuration registers;
// the row stores need no clearing; a held result stalls the pipeline, one further sample is still taken into stage one
module sharpen_3x3_stream #(
    parameter int MAX_WIDTH    = 2048,
    parameter int MAX_CHANNELS = 4
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        sample_valid,
    output logic        sample_ready,
    input  logic [7:0]  sample,

    output logic        result_valid,
    input  logic        result_ready,
    output logic [7:0]  pixel_value,
    output logic [11:0] out_row,
    output logic [12:0] out_index,
    output logic        frame_last,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SPAN  = MAX_WIDTH * MAX_CHANNELS;
    localparam int DEPTH = (SPAN < shrp_pkg::STORE_LIMIT) ? SPAN : shrp_pkg::STORE_LIMIT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CIW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    // clamp the raw registers to the geometry the filter really uses
    function automatic shrp_pkg::cfg_t derive_cfg(input logic [11:0] w_raw,
                                                  input logic [12:0] h_raw,
                                                  input logic [2:0]  c_raw);
        int c;
        int w;
        int h;
        int cap;
        shrp_pkg::cfg_t d;
        c = int'(c_raw);
        if (c < 1) c = 1;
        if (c > MAX_CHANNELS) c = MAX_CHANNELS;
        w = int'(w_raw);
        if (w < 3) w = 3;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        case (c)
            1:       cap = shrp_pkg::STORE_LIMIT;
            2:       cap = shrp_pkg::STORE_LIMIT / 2;
            3:       cap = shrp_pkg::STORE_LIMIT / 3;
            default: cap = shrp_pkg::STORE_LIMIT / 4;
        endcase
        if (w > cap) w = cap;
        h = int'(h_raw);
        if (h < 3) h = 3;
        if (h > shrp_pkg::HEIGHT_CAP) h = shrp_pkg::HEIGHT_CAP;
        d.chans     = 3'(c);
        d.len       = 14'(w * c);
        d.inner_end = 14'(w * c - c);
        d.height    = 13'(h);
        d.last_row  = 13'(h - 1);
        return d;
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [11:0]    width_reg, width_next;
    logic [12:0]    height_reg, height_next;
    logic [2:0]     chans_reg, chans_next;
    shrp_pkg::cfg_t geo_reg;
    logic           cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // register write decode
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        chans_next  = chans_reg;
        if (cfg_write)
        begin
            case (paddr[3:2])
                shrp_pkg::REG_WIDTH:    width_next  = pwdata[11:0];
                shrp_pkg::REG_HEIGHT:   height_next = pwdata[12:0];
                shrp_pkg::REG_CHANNELS: chans_next  = pwdata[2:0];
                default:                width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= shrp_pkg::WIDTH_RESET;
            height_reg <= shrp_pkg::HEIGHT_RESET;
            chans_reg  <= shrp_pkg::CHANNELS_RESET;
            geo_reg    <= derive_cfg(shrp_pkg::WIDTH_RESET, shrp_pkg::HEIGHT_RESET,
                                     shrp_pkg::CHANNELS_RESET);
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            chans_reg  <= chans_next;
            geo_reg    <= derive_cfg(width_next, height_next, chans_next);
        end
    end

    // register read-back
    always_comb
    begin
        case (paddr[3:2])
            shrp_pkg::REG_WIDTH:    prdata = {20'd0, width_reg};
            shrp_pkg::REG_HEIGHT:   prdata = {19'd0, height_reg};
            shrp_pkg::REG_CHANNELS: prdata = {29'd0, chans_reg};
            default:                prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // stage 0: raster position of the incoming request
    // ------------------------------------------------------------------
    logic [11:0] row_reg, row_next;
    logic [12:0] idx_reg, idx_next;
    logic        in_fire;
    logic        pre_wrap;
    logic [12:0] i0;
    logic [11:0] r_pre;
    logic [11:0] r0;
    logic [13:0] i_inc;
    logic [12:0] r_inc;
    logic        end_row;
    logic [13:0] right_idx;
    logic        border0;

    assign in_fire = sample_valid && sample_ready;

    always_comb
    begin
        // a shorter row or frame written while idle ends the current one
        pre_wrap = {1'b0, idx_reg} >= geo_reg.len;
        i0       = pre_wrap ? 13'd0 : idx_reg;
        r_pre    = pre_wrap ? row_reg + 12'd1 : row_reg;
        r0       = ({1'b0, r_pre} >= geo_reg.height) ? 12'd0 : r_pre;
        // step to the next position
        i_inc    = {1'b0, i0} + 14'd1;
        r_inc    = {1'b0, r0} + 13'd1;
        end_row  = i_inc >= geo_reg.len;
        idx_next = end_row ? 13'd0 : i_inc[12:0];
        if (end_row)
            row_next = (r_inc >= geo_reg.height) ? 12'd0 : r_inc[11:0];
        else
            row_next = r0;
        right_idx = {1'b0, i0} + {11'd0, geo_reg.chans};
        border0   = ({1'b0, i0} < {11'd0, geo_reg.chans}) || ({1'b0, i0} >= geo_reg.inner_end);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= 12'd0;
            idx_reg <= 13'd0;
        end
        else if (in_fire)
        begin
            row_reg <= row_next;
            idx_reg <= idx_next;
        end
    end

    // ------------------------------------------------------------------
    // row stores: newer holds the previous row, older the one before
    // ------------------------------------------------------------------
    logic [7:0]    newer_mem [DEPTH];
    logic [7:0]    older_mem [DEPTH];
    logic [7:0]    centre_rd_reg;
    logic [7:0]    right_rd_reg;
    logic [7:0]    up_rd_reg;
    logic [AW-1:0] addr0;
    logic [AW-1:0] addr_right;
    logic [AW-1:0] addr1;
    logic          s1_move;

    assign addr0      = i0[AW-1:0];
    assign addr_right = right_idx[AW-1:0];

    // newer store: two reads, replaced by the incoming sample
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            centre_rd_reg    <= newer_mem[addr0];
            right_rd_reg     <= newer_mem[addr_right];
            newer_mem[addr0] <= sample;
        end
    end

    // older store: read at accept, takes the displaced sample one stage later
    always_ff @(posedge clk)
    begin
        if (in_fire)
            up_rd_reg <= older_mem[addr0];
        if (s1_move)
            older_mem[addr1] <= centre_rd_reg;
    end

    // ------------------------------------------------------------------
    // stage 1: kernel arithmetic
    // ------------------------------------------------------------------
    logic        v1_reg;
    logic [12:0] idx1_reg;
    logic [11:0] row1_reg;
    logic [7:0]  down1_reg;
    logic        zero1_reg;
    logic        calc1_reg;
    logic        dual1_reg;
    logic        border1_reg;
    logic        last1_reg;
    logic        no_result1;
    logic        s2_free;
    logic [7:0]  left_reg [MAX_CHANNELS];
    logic [7:0]  left_val;
    logic [10:0] centre_x5;
    logic [9:0]  around_sum;
    logic [11:0] acc;
    logic [7:0]  sharp_val;

    assign addr1        = idx1_reg[AW-1:0];
    assign no_result1   = !zero1_reg && !calc1_reg;
    assign s1_move      = v1_reg && (no_result1 || s2_free);
    assign sample_ready = !v1_reg || s1_move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (in_fire)
            v1_reg <= 1'b1;
        else if (s1_move)
            v1_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            idx1_reg    <= i0;
            row1_reg    <= r0;
            down1_reg   <= sample;
            zero1_reg   <= r0 == 12'd0;
            calc1_reg   <= r0 >= 12'd2;
            dual1_reg   <= {1'b0, r0} == geo_reg.last_row;
            border1_reg <= border0;
            last1_reg   <= {1'b0, i0} == geo_reg.len - 14'd1;
        end
    end

    // previous-row samples of this row, one pixel back per channel
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            left_reg[0] <= centre_rd_reg;
            for (int k = 1; k < MAX_CHANNELS; k++)
                left_reg[k] <= left_reg[k-1];
        end
    end

    assign left_val = left_reg[CIW'(geo_reg.chans - 3'd1)];

    // 5 x centre minus the four neighbours, clamped to a byte
    always_comb
    begin
        centre_x5  = {1'b0, centre_rd_reg, 2'b00} + {3'b000, centre_rd_reg};
        around_sum = {2'b00, up_rd_reg} + {2'b00, left_val}
                   + {2'b00, right_rd_reg} + {2'b00, down1_reg};
        acc        = {1'b0, centre_x5} - {2'b00, around_sum};
        if (acc[11])
            sharp_val = 8'd0;
        else if (acc[10:8] != 3'd0)
            sharp_val = 8'd255;
        else
            sharp_val = acc[7:0];
    end

    // ------------------------------------------------------------------
    // stage 2: output register with a second slot for the final row
    // ------------------------------------------------------------------
    logic              o_valid_reg;
    logic              x_valid_reg;
    shrp_pkg::result_t o_data_reg;
    shrp_pkg::result_t x_data_reg;
    shrp_pkg::result_t res_a;
    shrp_pkg::result_t res_b;
    logic              out_fire;

    assign out_fire = o_valid_reg && result_ready;
    assign s2_free  = !o_valid_reg || (result_ready && !x_valid_reg);

    always_comb
    begin
        res_a.index = idx1_reg;
        res_a.last  = 1'b0;
        if (zero1_reg)
        begin
            res_a.value = 8'd0;
            res_a.row   = 12'd0;
        end
        else
        begin
            res_a.value = border1_reg ? 8'd0 : sharp_val;
            res_a.row   = row1_reg - 12'd1;
        end
        res_b.value = 8'd0;
        res_b.row   = row1_reg;
        res_b.index = idx1_reg;
        res_b.last  = last1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
            x_valid_reg <= 1'b0;
        end
        else if (s1_move && !no_result1)
        begin
            o_valid_reg <= 1'b1;
            x_valid_reg <= calc1_reg && dual1_reg;
        end
        else if (out_fire)
        begin
            o_valid_reg <= x_valid_reg;
            x_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && !no_result1)
        begin
            o_data_reg <= res_a;
            x_data_reg <= res_b;
        end
        else if (out_fire)
        begin
            o_data_reg <= x_data_reg;
        end
    end

    assign result_valid = o_valid_reg;
    assign pixel_value  = o_data_reg.value;
    assign out_row      = o_data_reg.row;
    assign out_index    = o_data_reg.index;
    assign frame_last   = o_data_reg.last;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // the second slot is only ever filled behind a waiting result
    a_second_behind_first: assert property (@(posedge clk) disable iff (!rst_n)
        x_valid_reg |-> o_valid_reg)
        else $error("second result slot holds data with the output register empty");

    // a request is refused only while stage one is occupied
    a_refuse_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> v1_reg)
        else $error("sample request refused with stage one empty");

    // the end of frame sits on a zero border sample at the end of a row
    a_frame_last_border: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && frame_last) |-> (pixel_value == 8'd0
            && {1'b0, out_index} == geo_reg.len - 14'd1))
        else $error("frame end marked on a sample that is not the last border sample");

endmodule
